### design/wat_pkg.sv
// ----------------------------------------------------------------------------
// wat_pkg
// Shared types and constants of the weekly alarm table matcher: item layouts,
// alarm entry layout, result kinds, night-mode codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wat_pkg;

  // Default number of alarm slots
  localparam int unsigned ALARM_COUNT_DEFAULT = 8;

  // Minute-of-day arithmetic
  localparam int unsigned MOD_W        = 11;
  localparam logic [MOD_W-1:0] MIN_PER_HOUR = MOD_W'(60);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_END   = 2'd2;

  // Input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Night-mode codes (code three behaves as off)
  localparam logic [1:0] NIGHT_OFF     = 2'd0;
  localparam logic [1:0] NIGHT_ALL_DAY = 2'd1;
  localparam logic [1:0] NIGHT_WINDOW  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  // Input item
  typedef struct packed {
    logic       op;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [2:0] now_weekday;
    logic [2:0] entry_index;
    logic       entry_enable;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [6:0] entry_week_mask;
    logic [7:0] entry_action;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] fired_index;
    logic [7:0] fired_action;
    logic       fired_one_shot;
    logic       any_enabled;
    logic       night_active;
    logic       last;
  } out_item_t;

  // One alarm table entry (27 bits)
  typedef struct packed {
    logic       en;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
    logic [7:0] action;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_ACK
  } seq_state_e;

endpackage

`default_nettype wire

### design/wat_ifs.sv
// ----------------------------------------------------------------------------
// wat_ifs
// Valid/ready channels of the alarm matcher: input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wat_in_if;
  import wat_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface wat_out_if;
  import wat_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

### design/weekly_alarm_table_matcher.sv
// ----------------------------------------------------------------------------
// weekly_alarm_table_matcher
// Alarm table with weekday masks, one-shot entries and a night-mode summary.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: a write item loads one alarm slot and clears its fired
//   latch; a tick item gives the current hour, minute and weekday.
//   out_o carries results: one kind-0 item per alarm that fires, in slot
//   order, then one summary; a write gives one acknowledge. last marks the
//   final result of an input item. Night mode and its window are set on the
//   cfg_* port; write them only while idle, which the block does not enforce.
// Timing:
//   A tick reads the table memory, which has a registered read port, one
//   slot per cycle while no firing slot waits for the result register; the
//   summary follows the last slot. One item is worked on at a time.
//   The result register lets the block run on while one result waits; a
//   stalled receiver holds the table walk only when a further result is due.
// Reset:
//   rst_ni clears all slots to disabled, all fired latches and all config
//   registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_alarm_table_matcher #(
  parameter int unsigned ALARM_COUNT = wat_pkg::ALARM_COUNT_DEFAULT
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wat_in_if.sink                               in_i,
  wat_out_if.source                            out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [wat_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [wat_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wat_pkg::*;

  localparam int unsigned IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

  logic [1:0]       night_mode_q;
  logic [MOD_W-1:0] night_start_q;
  logic [MOD_W-1:0] night_end_q;

  logic             tbl_wr_en;
  logic [IDX_W-1:0] tbl_wr_addr;
  entry_t           tbl_wr_data;
  logic [IDX_W-1:0] tbl_rd_addr;
  entry_t           tbl_rd_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      night_mode_q  <= NIGHT_OFF;
      night_start_q <= '0;
      night_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NIGHT_MODE:  night_mode_q  <= cfg_data_i[1:0];
        CFG_NIGHT_START: night_start_q <= cfg_data_i[MOD_W-1:0];
        CFG_NIGHT_END:   night_end_q   <= cfg_data_i[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Alarm entry memory
  wat_table #(
    .ALARM_COUNT (ALARM_COUNT)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (tbl_rd_data)
  );

  // Item sequencer
  wat_seq #(
    .ALARM_COUNT (ALARM_COUNT)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_item_i     (in_i.item),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_item_o    (out_o.item),
    .night_mode_i  (night_mode_q),
    .night_start_i (night_start_q),
    .night_end_i   (night_end_q),
    .tbl_wr_en_o   (tbl_wr_en),
    .tbl_wr_addr_o (tbl_wr_addr),
    .tbl_wr_data_o (tbl_wr_data),
    .tbl_rd_addr_o (tbl_rd_addr),
    .tbl_rd_data_i (tbl_rd_data)
  );

endmodule

`default_nettype wire

### design/wat_table.sv
// ----------------------------------------------------------------------------
// wat_table
// Alarm entry memory: one write port, one read port with registered data.
// Per-slot valid flops make unwritten slots read as a disabled zero entry.
// ----------------------------------------------------------------------------
`default_nettype none

module wat_table #(
  parameter int unsigned ALARM_COUNT = wat_pkg::ALARM_COUNT_DEFAULT,
  localparam int unsigned IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     wr_en_i,
  input  wire logic [IDX_W-1:0]         wr_addr_i,
  input  wire wat_pkg::entry_t          wr_data_i,
  input  wire logic [IDX_W-1:0]         rd_addr_i,
  output wat_pkg::entry_t               rd_data_o
);
  import wat_pkg::*;

  entry_t                 mem [ALARM_COUNT];
  logic [ALARM_COUNT-1:0] valid_q;
  entry_t                 rd_data_q;
  logic                   rd_valid_q;

  // Storage array and read register
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // Written-slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### design/wat_seq.sv
// ----------------------------------------------------------------------------
// wat_seq
// Item sequencer: loads entries on write items, walks the table one slot per
// cycle on tick items (a firing waits for slot_free) with read-modify-write
// of one-shot entries, keeps the fired latches, drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wat_seq #(
  parameter int unsigned ALARM_COUNT = wat_pkg::ALARM_COUNT_DEFAULT,
  localparam int unsigned IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input item channel
  input  wire logic                         in_valid_i,
  input  wire wat_pkg::in_item_t            in_item_i,
  output logic                              in_ready_o,
  // result channel
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output wat_pkg::out_item_t                out_item_o,
  // configuration
  input  wire logic [1:0]                   night_mode_i,
  input  wire logic [wat_pkg::MOD_W-1:0]    night_start_i,
  input  wire logic [wat_pkg::MOD_W-1:0]    night_end_i,
  // table port
  output logic                              tbl_wr_en_o,
  output logic [IDX_W-1:0]                  tbl_wr_addr_o,
  output wat_pkg::entry_t                   tbl_wr_data_o,
  output logic [IDX_W-1:0]                  tbl_rd_addr_o,
  input  wire wat_pkg::entry_t              tbl_rd_data_i
);
  import wat_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_COUNT - 1);

  seq_state_e             state_q, state_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [MOD_W-1:0]       nowm_q;
  logic [6:0]             wbit_q;
  logic                   anyen_q;
  logic [ALARM_COUNT-1:0] latch_q;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic             accept;
  logic             is_write;
  logic             idx_ok;
  logic             slot_free;
  logic [MOD_W-1:0] slot_m;
  logic [MOD_W-1:0] in_m;
  logic [6:0]       in_wbit;
  logic             match;
  logic             one_shot;
  logic             fire;
  logic             advance;
  logic             last_slot;
  logic             night;
  logic             load;

  // Decode of the incoming item and the slot under evaluation
  always_comb begin
    accept    = in_valid_i && (state_q == ST_IDLE);
    is_write  = (in_item_i.op == OP_WRITE);
    idx_ok    = (32'(in_item_i.entry_index) < ALARM_COUNT);
    in_m      = MOD_W'(in_item_i.now_hour) * MIN_PER_HOUR + MOD_W'(in_item_i.now_minute);
    in_wbit   = (in_item_i.now_weekday == 3'd0) ? 7'd0
                : (7'd1 << (in_item_i.now_weekday - 3'd1));
    slot_free = !out_valid_q || out_ready_i;
    slot_m    = MOD_W'(tbl_rd_data_i.hour) * MIN_PER_HOUR + MOD_W'(tbl_rd_data_i.minute);
    match     = (slot_m == nowm_q);
    one_shot  = (tbl_rd_data_i.mask == 7'd0);
    fire      = tbl_rd_data_i.en && match && !latch_q[idx_q]
                && (one_shot || ((tbl_rd_data_i.mask & wbit_q) != 7'd0));
    advance   = (state_q == ST_SCAN) && (!fire || slot_free);
    last_slot = (idx_q == LAST_IDX);
  end

  // Night-mode check, with the window tested on the captured minute of day
  always_comb begin
    case (night_mode_i)
      NIGHT_ALL_DAY: night = 1'b1;
      NIGHT_WINDOW: begin
        if (night_start_i < night_end_i) begin
          night = (nowm_q >= night_start_i) && (nowm_q < night_end_i);
        end else begin
          night = (nowm_q >= night_start_i) || (nowm_q < night_end_i);
        end
      end
      default: night = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = is_write ? ST_ACK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && last_slot) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: table access, slot index and result loading
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    tbl_wr_en_o   = 1'b0;
    tbl_wr_addr_o = idx_q;
    tbl_wr_data_o = tbl_rd_data_i;
    tbl_rd_addr_o = '0;
    idx_d         = idx_q;
    load          = 1'b0;
    out_item_d    = '0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept && is_write && idx_ok) begin
          tbl_wr_en_o   = 1'b1;
          tbl_wr_addr_o = IDX_W'(in_item_i.entry_index);
          tbl_wr_data_o = '{en:     in_item_i.entry_enable,
                            hour:   in_item_i.entry_hour,
                            minute: in_item_i.entry_minute,
                            mask:   in_item_i.entry_week_mask,
                            action: in_item_i.entry_action};
        end
      end
      ST_SCAN: begin
        // re-read the same slot while a firing waits for the result register
        tbl_rd_addr_o = idx_q;
        if (advance) begin
          idx_d         = last_slot ? '0 : idx_q + IDX_W'(1);
          tbl_rd_addr_o = idx_d;
        end
        if (advance && fire) begin
          load                      = 1'b1;
          out_item_d.kind           = KIND_FIRED;
          out_item_d.fired_index    = 3'(idx_q);
          out_item_d.fired_action   = tbl_rd_data_i.action;
          out_item_d.fired_one_shot = one_shot;
          // one-shot entries disable themselves
          if (one_shot) begin
            tbl_wr_en_o      = 1'b1;
            tbl_wr_data_o.en = 1'b0;
          end
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          load                    = 1'b1;
          out_item_d.kind         = KIND_SUMMARY;
          out_item_d.any_enabled  = anyen_q;
          out_item_d.night_active = night;
          out_item_d.last         = 1'b1;
        end
      end
      ST_ACK: begin
        if (slot_free) begin
          load            = 1'b1;
          out_item_d.kind = KIND_ACK;
          out_item_d.last = 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Control registers and fired latches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      anyen_q     <= 1'b0;
      latch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (accept && !is_write) begin
        anyen_q <= 1'b0;
      end else if (advance && tbl_rd_data_i.en) begin
        anyen_q <= 1'b1;
      end
      if (accept && is_write && idx_ok) begin
        latch_q[IDX_W'(in_item_i.entry_index)] <= 1'b0;
      end else if (advance && tbl_rd_data_i.en) begin
        latch_q[idx_q] <= match;
      end
    end
  end

  // Tick payload and result register
  always_ff @(posedge clk_i) begin
    if (accept && !is_write) begin
      nowm_q <= in_m;
      wbit_q <= in_wbit;
    end
    if (load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
